>>> sv/tsas_pkg.sv
// Shared types, register codes and constants of the terrain slope and aspect stencil.
`default_nettype none

package tsas_pkg;

   // Height sample width and angle resolution; both shape the transfer types below.
   localparam int HEIGHT_BITS = 24;
   localparam int ANGLE_BITS  = 16;

   // One input transfer: a height sample or a drain request.
   typedef struct packed {
      logic                        cmd;
      logic signed [HEIGHT_BITS-1:0] elevation;
   } req_type;

   // One result transfer.
   typedef struct packed {
      logic [ANGLE_BITS-2:0] slope_angle;
      logic [ANGLE_BITS-1:0] aspect_angle;
      logic                  frame_last;
   } rsp_type;

   localparam int CSR_DATA_BITS = 16;

   typedef enum logic [1:0] {
      CSR_GRID_COLUMNS  = 2'd0,
      CSR_GRID_ROWS     = 2'd1,
      CSR_INV_SPACING_X = 2'd2,
      CSR_INV_SPACING_Y = 2'd3
   } csr_index_type;

   // How the north-south difference of a pixel is formed.
   typedef enum logic [1:0] {
      DY_ZERO,
      DY_FIRST_ROW,
      DY_BODY,
      DY_LAST_ROW
   } dy_mode_type;

   localparam logic [10:0] GRID_COLUMNS_RESET = 11'd1024;
   localparam logic [15:0] GRID_ROWS_RESET    = 16'd1024;
   localparam logic [15:0] INV_SPACING_RESET  = 16'd4096;

   localparam logic [31:0] HALF_TURN    = 32'h8000_0000;
   localparam logic [30:0] QUARTER_TURN = 31'h4000_0000;
   localparam int          GAIN_Q21     = 3453507;

   // Arctangent of 2^-i in units of 2^32 per turn, truncated.
   function automatic logic [31:0] atan_entry(input int i);
      logic [31:0] r;
      case (i)
         0:  r = 32'h20000000;
         1:  r = 32'h12E4051D;
         2:  r = 32'h09FB385B;
         3:  r = 32'h051111D4;
         4:  r = 32'h028B0D43;
         5:  r = 32'h0145D7E1;
         6:  r = 32'h00A2F61E;
         7:  r = 32'h00517C55;
         8:  r = 32'h0028BE53;
         9:  r = 32'h00145F2E;
         10: r = 32'h000A2F98;
         11: r = 32'h000517CC;
         12: r = 32'h00028BE6;
         13: r = 32'h000145F3;
         14: r = 32'h0000A2F9;
         15: r = 32'h0000517C;
         16: r = 32'h000028BE;
         17: r = 32'h0000145F;
         18: r = 32'h00000A2F;
         19: r = 32'h00000517;
         20: r = 32'h0000028B;
         21: r = 32'h00000145;
         22: r = 32'h000000A2;
         23: r = 32'h00000051;
         default: r = 32'h0;
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

>>> sv/tsas_lbuf.sv
// Line buffer: one row of heights, kept in two copies for three reads per cycle.
`default_nettype none

module tsas_lbuf #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 24
) (
   input  logic                     clock,
   input  logic                     read_enable,
   input  logic                     write_enable,
   input  logic [$clog2(DEPTH)-1:0] write_addr,
   input  logic signed [WIDTH-1:0]  write_data,
   input  logic [$clog2(DEPTH)-1:0] lo_addr,
   input  logic [$clog2(DEPTH)-1:0] hi_addr,
   input  logic [$clog2(DEPTH)-1:0] mid_addr,
   output logic signed [WIDTH-1:0]  lo_data,
   output logic signed [WIDTH-1:0]  hi_data,
   output logic signed [WIDTH-1:0]  mid_data
);

   logic signed [WIDTH-1:0] edge_ram [DEPTH];
   logic signed [WIDTH-1:0] center_ram [DEPTH];
   logic signed [WIDTH-1:0] lo_ff;
   logic signed [WIDTH-1:0] hi_ff;
   logic signed [WIDTH-1:0] mid_ff;

   // A read at the address being written returns the old contents.
   always_ff @(posedge clock) begin
      if (write_enable) begin
         edge_ram[write_addr]   <= write_data;
         center_ram[write_addr] <= write_data;
      end
      if (read_enable) begin
         lo_ff  <= edge_ram[lo_addr];
         hi_ff  <= edge_ram[hi_addr];
         mid_ff <= center_ram[mid_addr];
      end
   end

   assign lo_data  = lo_ff;
   assign hi_data  = hi_ff;
   assign mid_data = mid_ff;

endmodule

`default_nettype wire

>>> sv/tsas_cordic.sv
// Pipelined CORDIC vectoring unit with a half-turn pre-rotation and a sideband.
`default_nettype none

module tsas_cordic #(
   parameter int W      = 47,
   parameter int STAGES = 16,
   parameter int SBW    = 3
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  logic                in_valid,
   input  logic signed [W-1:0] in_x,
   input  logic signed [W-1:0] in_y,
   input  logic [SBW-1:0]      in_sb,
   output logic                out_valid,
   output logic signed [W-1:0] out_x,
   output logic [31:0]         out_angle,
   output logic [SBW-1:0]      out_sb
);
   import tsas_pkg::*;

   logic                v_ff   [STAGES+1];
   logic signed [W-1:0] x_ff   [STAGES+1];
   logic signed [W-1:0] y_ff   [STAGES+1];
   logic [31:0]         acc_ff [STAGES+1];
   logic [SBW-1:0]      sb_ff  [STAGES+1];
   logic signed [W-1:0] x_in   [STAGES+1];
   logic signed [W-1:0] y_in   [STAGES+1];
   logic [31:0]         acc_in [STAGES+1];

   always_comb begin
      if (in_x[W-1]) begin
         x_in[0]   = -in_x;
         y_in[0]   = -in_y;
         acc_in[0] = HALF_TURN;
      end else begin
         x_in[0]   = in_x;
         y_in[0]   = in_y;
         acc_in[0] = '0;
      end
      for (int i = 0; i < STAGES; i++) begin
         if (!y_ff[i][W-1]) begin
            x_in[i+1]   = x_ff[i] + (y_ff[i] >>> i);
            y_in[i+1]   = y_ff[i] - (x_ff[i] >>> i);
            acc_in[i+1] = acc_ff[i] + atan_entry(i);
         end else begin
            x_in[i+1]   = x_ff[i] - (y_ff[i] >>> i);
            y_in[i+1]   = y_ff[i] + (x_ff[i] >>> i);
            acc_in[i+1] = acc_ff[i] - atan_entry(i);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= STAGES; i++) v_ff[i] <= 1'b0;
      end else if (advance) begin
         v_ff[0] <= in_valid;
         for (int i = 0; i < STAGES; i++) v_ff[i+1] <= v_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         sb_ff[0] <= in_sb;
         for (int i = 0; i <= STAGES; i++) begin
            x_ff[i]   <= x_in[i];
            y_ff[i]   <= y_in[i];
            acc_ff[i] <= acc_in[i];
         end
         for (int i = 0; i < STAGES; i++) sb_ff[i+1] <= sb_ff[i];
      end
   end

   assign out_valid = v_ff[STAGES];
   assign out_x     = x_ff[STAGES];
   assign out_angle = acc_ff[STAGES];
   assign out_sb    = sb_ff[STAGES];

endmodule

`default_nettype wire

>>> sv/terrain_slope_aspect_stencil.sv
// Terrain slope and aspect stencil: line buffers, gradient stages and two CORDIC pipelines.
// A result leaves the output register after the line buffer read, the three gradient stages and
// the two CORDIC pipelines. Throughput: one item per cycle unless a held output result stalls
// every stage; the line buffers serve all reads of a pixel in one cycle.
// Reset: synchronous, active high; clears counters, valid bits and the registers to their
// reset values. Line buffer contents are undefined until written; there is no clearing pass.
`default_nettype none

module terrain_slope_aspect_stencil #(
   parameter int MAX_COLUMNS   = 1024,
   parameter int CORDIC_STAGES = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  tsas_pkg::req_type              req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output tsas_pkg::rsp_type              rsp_data,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  tsas_pkg::csr_index_type        csr_index,
   input  logic [tsas_pkg::CSR_DATA_BITS-1:0] csr_data
);
   import tsas_pkg::*;

   // Column address width, counter compare width and datapath widths.
   localparam int AW   = $clog2(MAX_COLUMNS);
   localparam int CNTW = $clog2(MAX_COLUMNS + 1);
   localparam int CMPW = ((CNTW > 11) ? CNTW : 11) + 1;
   localparam int HB   = HEIGHT_BITS;
   localparam int DW   = HB + 1;
   localparam int PW   = DW + 17;
   localparam int CW   = HB + 23;
   localparam int RSH  = 32 - ANGLE_BITS;
   localparam logic [32:0] ROUND_HALF = 33'(1) << (RSH - 1);
   localparam logic [32:0] ANGLE_MASK = (33'(1) << ANGLE_BITS) - 33'(1);

   // ---------------------------------------------------------------------------------------
   // Configuration registers. The port always takes a transfer.
   // ---------------------------------------------------------------------------------------
   logic [10:0] grid_columns_ff;
   logic [15:0] grid_rows_ff;
   logic [15:0] inv_spacing_x_ff;
   logic [15:0] inv_spacing_y_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_columns_ff  <= GRID_COLUMNS_RESET;
         grid_rows_ff     <= GRID_ROWS_RESET;
         inv_spacing_x_ff <= INV_SPACING_RESET;
         inv_spacing_y_ff <= INV_SPACING_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_GRID_COLUMNS:  grid_columns_ff  <= csr_data[10:0];
            CSR_GRID_ROWS:     grid_rows_ff     <= csr_data;
            CSR_INV_SPACING_X: inv_spacing_x_ff <= csr_data;
            CSR_INV_SPACING_Y: inv_spacing_y_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------------------------------
   // Pipeline control. Every stage moves together unless a finished result is held at the
   // output, so the block keeps taking transfers while earlier pixels are still in flight.
   // ---------------------------------------------------------------------------------------
   logic adv;
   logic rsp_valid_ff;
   rsp_type rsp_data_ff;

   assign adv       = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !adv;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // ---------------------------------------------------------------------------------------
   // Raster position. The column count picks the line buffer entry; the row count tells
   // the first row, the body of the frame and the drain phase apart.
   // ---------------------------------------------------------------------------------------
   logic [AW-1:0] column_count_ff, column_count_in;
   logic [15:0]   row_count_ff, row_count_in;
   logic          buffer_select_ff, buffer_select_in;

   logic [CMPW-1:0] gc_ext, cols, cc_ext, x_cmp;
   logic [15:0]     rows;
   logic [AW-1:0]   x, lo_addr, hi_addr;
   logic            col_last, single_col, at_first, at_end, in_frame;
   logic            accept, push_ok, drain_ok, emit, step;
   dy_mode_type     dy_mode;
   logic signed [31:0] elev_ext;
   logic signed [HB-1:0] z;

   always_comb begin
      gc_ext = CMPW'(grid_columns_ff);
      if (grid_columns_ff == '0) begin
         cols = CMPW'(1);
      end else if (gc_ext > CMPW'(MAX_COLUMNS)) begin
         cols = CMPW'(MAX_COLUMNS);
      end else begin
         cols = gc_ext;
      end
      rows = (grid_rows_ff == '0) ? 16'd1 : grid_rows_ff;

      // A column count left beyond a narrowed row acts as the last column.
      cc_ext     = CMPW'(column_count_ff);
      x_cmp      = (cc_ext < cols) ? cc_ext : cols - CMPW'(1);
      x          = x_cmp[AW-1:0];
      col_last   = (cc_ext + CMPW'(1)) >= cols;
      single_col = cols == CMPW'(1);
      at_first   = x_cmp == '0;
      at_end     = x_cmp == cols - CMPW'(1);
      lo_addr    = at_first ? '0 : x - AW'(1);
      hi_addr    = at_end ? x : x + AW'(1);
      in_frame   = row_count_ff < rows;

      accept   = req_valid && !req_stall;
      push_ok  = accept && !req_data.cmd && in_frame;
      drain_ok = accept && req_data.cmd && !in_frame;
      emit     = (push_ok && row_count_ff != '0) || drain_ok;
      step     = push_ok || drain_ok;

      if (!req_data.cmd) begin
         dy_mode = (row_count_ff == 16'd1) ? DY_FIRST_ROW : DY_BODY;
      end else begin
         dy_mode = (rows >= 16'd2) ? DY_LAST_ROW : DY_ZERO;
      end

      elev_ext = 32'(req_data.elevation);
      z        = elev_ext[HB-1:0];

      column_count_in  = column_count_ff;
      row_count_in     = row_count_ff;
      buffer_select_in = buffer_select_ff;
      if (step) begin
         if (col_last) begin
            column_count_in = '0;
            if (push_ok) begin
               buffer_select_in = !buffer_select_ff;
               row_count_in     = row_count_ff + 16'd1;
            end else begin
               row_count_in = '0;
            end
         end else begin
            column_count_in = column_count_ff + AW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_count_ff  <= '0;
         row_count_ff     <= '0;
         buffer_select_ff <= 1'b0;
      end else begin
         column_count_ff  <= column_count_in;
         row_count_ff     <= row_count_in;
         buffer_select_ff <= buffer_select_in;
      end
   end

   // ---------------------------------------------------------------------------------------
   // Line buffers. The selected buffer holds the previous row; the other one holds the row
   // before it and takes the incoming sample at the same column, read before write.
   // ---------------------------------------------------------------------------------------
   logic we_a, we_b;
   logic signed [HB-1:0] a_lo, a_hi, a_mid, b_lo, b_hi, b_mid;

   assign we_a = push_ok && buffer_select_ff;
   assign we_b = push_ok && !buffer_select_ff;

   tsas_lbuf #(.DEPTH(MAX_COLUMNS), .WIDTH(HB)) u_lbuf_a (
      .clock        (clock),
      .read_enable  (adv),
      .write_enable (we_a),
      .write_addr   (x),
      .write_data   (z),
      .lo_addr      (lo_addr),
      .hi_addr      (hi_addr),
      .mid_addr     (x),
      .lo_data      (a_lo),
      .hi_data      (a_hi),
      .mid_data     (a_mid)
   );

   tsas_lbuf #(.DEPTH(MAX_COLUMNS), .WIDTH(HB)) u_lbuf_b (
      .clock        (clock),
      .read_enable  (adv),
      .write_enable (we_b),
      .write_addr   (x),
      .write_data   (z),
      .lo_addr      (lo_addr),
      .hi_addr      (hi_addr),
      .mid_addr     (x),
      .lo_data      (b_lo),
      .hi_data      (b_hi),
      .mid_data     (b_mid)
   );

   // ---------------------------------------------------------------------------------------
   // Stage 1: buffer data arrives; form the height differences.
   // ---------------------------------------------------------------------------------------
   logic                 s1_valid_ff;
   logic                 s1_sel_ff, s1_zero_dx_ff, s1_dbl_x_ff, s1_last_ff;
   dy_mode_type          s1_mode_ff;
   logic signed [HB-1:0] s1_z_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= emit;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_sel_ff     <= buffer_select_ff;
         s1_zero_dx_ff <= single_col;
         s1_dbl_x_ff   <= at_first || at_end;
         s1_last_ff    <= req_data.cmd && col_last;
         s1_mode_ff    <= dy_mode;
         s1_z_ff       <= z;
      end
   end

   logic signed [HB-1:0] prev_lo, prev_hi, prev_mid, older_mid;
   logic signed [DW-1:0] dx_diff, dy_diff;
   logic                 dy_dbl;

   always_comb begin
      prev_lo   = s1_sel_ff ? b_lo : a_lo;
      prev_hi   = s1_sel_ff ? b_hi : a_hi;
      prev_mid  = s1_sel_ff ? b_mid : a_mid;
      older_mid = s1_sel_ff ? a_mid : b_mid;
      dx_diff   = s1_zero_dx_ff ? '0 : DW'(prev_hi) - DW'(prev_lo);
      case (s1_mode_ff)
         DY_FIRST_ROW: begin
            dy_diff = DW'(s1_z_ff) - DW'(prev_mid);
            dy_dbl  = 1'b1;
         end
         DY_BODY: begin
            dy_diff = DW'(s1_z_ff) - DW'(older_mid);
            dy_dbl  = 1'b0;
         end
         DY_LAST_ROW: begin
            dy_diff = DW'(prev_mid) - DW'(older_mid);
            dy_dbl  = 1'b1;
         end
         default: begin
            dy_diff = '0;
            dy_dbl  = 1'b0;
         end
      endcase
   end

   // ---------------------------------------------------------------------------------------
   // Stage 2: scale by the inverse spacings. A one-sided difference counts double, so
   // both gradients are exact integers in Q.21.
   // ---------------------------------------------------------------------------------------
   logic                 s2_valid_ff;
   logic signed [DW-1:0] s2_dx_diff_ff, s2_dy_diff_ff;
   logic                 s2_dbl_x_ff, s2_dbl_y_ff, s2_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (adv) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_dx_diff_ff <= dx_diff;
         s2_dy_diff_ff <= dy_diff;
         s2_dbl_x_ff   <= s1_dbl_x_ff;
         s2_dbl_y_ff   <= dy_dbl;
         s2_last_ff    <= s1_last_ff;
      end
   end

   logic signed [PW-2:0] prod_x, prod_y;
   logic signed [CW-1:0] dx_in, dy_in;

   always_comb begin
      prod_x = s2_dx_diff_ff * $signed({1'b0, inv_spacing_x_ff});
      prod_y = s2_dy_diff_ff * $signed({1'b0, inv_spacing_y_ff});
      dx_in  = s2_dbl_x_ff ? (CW'(prod_x) <<< 1) : CW'(prod_x);
      dy_in  = s2_dbl_y_ff ? (CW'(prod_y) <<< 1) : CW'(prod_y);
   end

   // ---------------------------------------------------------------------------------------
   // Stage 3: gradients registered; the aspect vector (dy, -dx) enters the first CORDIC.
   // ---------------------------------------------------------------------------------------
   logic                 s3_valid_ff, s3_last_ff;
   logic signed [CW-1:0] s3_dx_ff, s3_dy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (adv) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s3_dx_ff   <= dx_in;
         s3_dy_ff   <= dy_in;
         s3_last_ff <= s2_last_ff;
      end
   end

   logic                 c1_valid;
   logic signed [CW-1:0] c1_mag;
   logic [31:0]          c1_angle;
   logic [2:0]           c1_sb;

   tsas_cordic #(.W(CW), .STAGES(CORDIC_STAGES), .SBW(3)) u_cordic_aspect (
      .clock     (clock),
      .reset     (reset),
      .advance   (adv),
      .in_valid  (s3_valid_ff),
      .in_x      (s3_dy_ff),
      .in_y      (-s3_dx_ff),
      .in_sb     ({s3_last_ff, s3_dx_ff == '0, s3_dy_ff[CW-1]}),
      .out_valid (c1_valid),
      .out_x     (c1_mag),
      .out_angle (c1_angle),
      .out_sb    (c1_sb)
   );

   // A vector on the north-south axis gets an exact aspect of zero or a half turn. The
   // scaled magnitude then feeds the slope vectoring against gain * 2^21.
   logic [31:0] aspect_fix;
   logic        mag_pos;

   always_comb begin
      if (c1_sb[1]) begin
         aspect_fix = c1_sb[0] ? HALF_TURN : '0;
      end else begin
         aspect_fix = c1_angle;
      end
      mag_pos = !c1_mag[CW-1] && (c1_mag != '0);
   end

   logic        c2_valid;
   logic [31:0] c2_angle;
   logic [33:0] c2_sb;

   tsas_cordic #(.W(CW), .STAGES(CORDIC_STAGES), .SBW(34)) u_cordic_slope (
      .clock     (clock),
      .reset     (reset),
      .advance   (adv),
      .in_valid  (c1_valid),
      .in_x      (CW'(GAIN_Q21)),
      .in_y      (c1_mag),
      .in_sb     ({c1_sb[2], mag_pos, aspect_fix}),
      .out_valid (c2_valid),
      .out_x     (),
      .out_angle (c2_angle),
      .out_sb    (c2_sb)
   );

   // ---------------------------------------------------------------------------------------
   // Output: clamp the slope to between zero and a quarter turn, round both angles half up and register.
   // ---------------------------------------------------------------------------------------
   logic [31:0] slope_raw, slope_clamped;
   logic [32:0] slope_round, aspect_round;
   rsp_type     rsp_next;

   always_comb begin
      slope_raw = c2_sb[32] ? c2_angle : '0;
      if (slope_raw[31]) begin
         slope_clamped = '0;
      end else if (slope_raw[30:0] > QUARTER_TURN) begin
         slope_clamped = {1'b0, QUARTER_TURN};
      end else begin
         slope_clamped = {1'b0, slope_raw[30:0]};
      end
      slope_round  = ((({1'b0, slope_clamped} + ROUND_HALF) >> RSH)) & ANGLE_MASK;
      aspect_round = ((({1'b0, c2_sb[31:0]} + ROUND_HALF) >> RSH)) & ANGLE_MASK;
      rsp_next.slope_angle  = slope_round[ANGLE_BITS-2:0];
      rsp_next.aspect_angle = aspect_round[ANGLE_BITS-1:0];
      rsp_next.frame_last   = c2_sb[33];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= c2_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_data_ff <= rsp_next;
      end
   end

`ifndef SYNTHESIS
   // The final drain of a frame rewinds the raster position to the first pixel.
   a_drain_rewinds: assert property (@(posedge clock) disable iff (reset)
      drain_ok && col_last |=> column_count_ff == '0 && row_count_ff == '0)
      else $error("last drain did not rewind the raster position");

   // Finishing a pushed row swaps the roles of the two line buffers.
   a_row_swaps_buffers: assert property (@(posedge clock) disable iff (reset)
      push_ok && col_last |=> buffer_select_ff != $past(buffer_select_ff))
      else $error("completed row did not swap line buffers");

   // A drain never moves on to a further row.
   a_drain_keeps_row: assert property (@(posedge clock) disable iff (reset)
      drain_ok |=> row_count_ff == $past(row_count_ff) || row_count_ff == '0)
      else $error("drain changed the row count");
`endif

endmodule

`default_nettype wire

>>> test/tb.sv
// Self-checking regression bench for the terrain slope and aspect stencil.
`default_nettype none

module tb;
   import tsas_pkg::*;

   // Clock, reset and the block's ports.
   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;
   logic    csr_valid;
   logic    csr_ready;
   csr_index_type csr_index;
   logic [CSR_DATA_BITS-1:0] csr_data;

   localparam int LINE_DEPTH = 1024;
   localparam int STAGES     = 16;
   localparam int SETTLE     = 80;       // Covers the pipeline plus margin.
   localparam int LIMIT      = 1500000;

   terrain_slope_aspect_stencil dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   // Arctangent of 2^-i, 2^32 units per turn, truncated.
   localparam logic [31:0] ARCTAN [0:STAGES-1] = '{
      32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4,
      32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
      32'h0028BE53, 32'h00145F2E, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C
   };

   // Predictor state: a private copy of the registers, line buffers and raster position.
   logic [10:0] grid_cols_reg;
   logic [15:0] grid_rows_reg;
   logic [15:0] inv_dx_reg;
   logic [15:0] inv_dy_reg;
   longint      row_prev_a [LINE_DEPTH];
   longint      row_prev_b [LINE_DEPTH];
   int unsigned pixel_col;
   int unsigned pixel_row;
   bit          line_toggle;

   req_type pending_items [$];
   rsp_type expected_angles [$];
   int      mismatch_count;
   int      result_count;
   int      accepted_count;
   int      queued_count;
   int      frame_count;
   int      cycle_count;

   function automatic int unsigned active_cols();
      if (grid_cols_reg == 0) return 1;
      if (grid_cols_reg > LINE_DEPTH) return LINE_DEPTH;
      return 32'(grid_cols_reg);
   endfunction

   function automatic int unsigned active_rows();
      return (grid_rows_reg == 0) ? 1 : 32'(grid_rows_reg);
   endfunction

   // Vectoring CORDIC; a vector in the left half-plane is first turned by a half turn.
   // The >>> on a longint floors, which is what the hardware shifter does.
   function automatic logic [31:0] cordic_vector(input longint xin, input longint yin,
                                                 output longint magnitude);
      longint      x;
      longint      y;
      longint      xs;
      longint      ys;
      logic [31:0] phase;
      x = xin;
      y = yin;
      phase = 32'h0;
      if (x < 0) begin
         x = -x;
         y = -y;
         phase = HALF_TURN;
      end
      for (int i = 0; i < STAGES; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (y >= 0) begin
            x = x + ys;
            y = y - xs;
            phase = phase + ARCTAN[i];
         end else begin
            x = x - ys;
            y = y + xs;
            phase = phase - ARCTAN[i];
         end
      end
      magnitude = x;
      return phase;
   endfunction

   // Round half up from 32-bit turns to 16-bit turns, wrapping at one turn.
   function automatic logic [15:0] round_turns(input logic [31:0] phase);
      logic [32:0] sum;
      sum = {1'b0, phase} + 33'h8000;
      return sum[31:16];
   endfunction

   // East-west gradient in Q.21: central inside the row, one-sided and doubled at borders.
   function automatic longint east_west_slope(input bit from_b, input int unsigned x,
                                              input int unsigned cols);
      longint lo;
      longint hi;
      longint weight;
      int unsigned left;
      int unsigned right;
      if (cols <= 1) return 0;
      if (x == 0) begin
         left = 0; right = 1; weight = 2;
      end else if (x >= cols - 1) begin
         left = cols - 2; right = cols - 1; weight = 2;
      end else begin
         left = x - 1; right = x + 1; weight = 1;
      end
      lo = from_b ? row_prev_b[left] : row_prev_a[left];
      hi = from_b ? row_prev_b[right] : row_prev_a[right];
      return (hi - lo) * longint'(inv_dx_reg) * weight;
   endfunction

   function automatic rsp_type slope_aspect(input longint dx, input longint dy, input bit last);
      rsp_type     r;
      longint      magnitude;
      longint      unused_mag;
      logic [31:0] aspect;
      logic [31:0] slope;
      logic [15:0] slope_rounded;
      aspect = cordic_vector(dy, -dx, magnitude);
      slope = 32'h0;
      // Pure north or south: the aspect is exact rather than the CORDIC residue.
      if (dx == 0) aspect = (dy < 0) ? HALF_TURN : 32'h0;
      if (magnitude > 0) begin
         slope = cordic_vector(longint'(GAIN_Q21), magnitude, unused_mag);
         if (slope[31]) slope = 32'h0;
         else if (slope[30:0] > QUARTER_TURN) slope = {1'b0, QUARTER_TURN};
      end
      slope_rounded = round_turns(slope);
      r.slope_angle  = slope_rounded[14:0];
      r.aspect_angle = round_turns(aspect);
      r.frame_last   = last;
      return r;
   endfunction

   // Advances the raster position for one accepted transfer and queues its result, if any.
   function automatic void predict_stencil(input req_type item);
      int unsigned cols;
      int unsigned rows;
      int unsigned x;
      longint      z;
      longint      above;
      longint      older_z;
      longint      dx;
      longint      dy;
      bit          last;
      cols = active_cols();
      rows = active_rows();
      x = (pixel_col < cols) ? pixel_col : cols - 1;
      // line_toggle selects the buffer with the previous row; the other holds the row before.
      above = line_toggle ? row_prev_b[x] : row_prev_a[x];
      older_z = line_toggle ? row_prev_a[x] : row_prev_b[x];
      if (!item.cmd) begin
         if (pixel_row >= rows) return;   // Pushes during the drain phase are dropped.
         z = longint'(item.elevation);
         if (pixel_row >= 1) begin
            dx = east_west_slope(line_toggle, x, cols);
            if (pixel_row == 1) dy = (z - above) * longint'(inv_dy_reg) * 2;
            else dy = (z - older_z) * longint'(inv_dy_reg);
            expected_angles.insert(expected_angles.size(), slope_aspect(dx, dy, 1'b0));
         end
         if (line_toggle) row_prev_a[x] = z;
         else row_prev_b[x] = z;
         if (pixel_col + 1 >= cols) begin
            pixel_col = 0;
            line_toggle = !line_toggle;
            pixel_row++;
         end else begin
            pixel_col++;
         end
      end else begin
         if (pixel_row < rows) return;    // A drain before the frame is complete is dropped.
         dx = east_west_slope(line_toggle, x, cols);
         dy = (rows >= 2) ? (above - older_z) * longint'(inv_dy_reg) * 2 : 0;
         last = (pixel_col + 1 >= cols);
         expected_angles.insert(expected_angles.size(), slope_aspect(dx, dy, last));
         if (last) begin
            pixel_col = 0;
            pixel_row = 0;
         end else begin
            pixel_col++;
         end
      end
   endfunction

   // Sender: bursts of random length with random gaps, fed from pending_items.
   // The predictor runs on every accepted transfer at the edge that accepts it.
   int burst_left;
   int gap_left;

   always @(posedge clock) begin
      if (reset) begin
         req_valid  <= 1'b0;
         req_data   <= '0;
         burst_left <= 8;
         gap_left   <= 0;
      end else begin
         if (req_valid && !req_stall) begin
            predict_stencil(req_data);
            accepted_count++;
         end
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left  <= gap_left - 1;
               req_valid <= 1'b0;
            end else if (pending_items.size() > 0) begin
               req_valid <= 1'b1;
               req_data  <= pending_items.pop_front();
               if (burst_left <= 1) begin
                  burst_left <= $urandom_range(1, 24);
                  gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
               end else begin
                  burst_left <= burst_left - 1;
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver: the stall pattern switches among styles, from none to long stalls.
   int stall_style;

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall   <= 1'b0;
         stall_style <= 0;
      end else begin
         if (cycle_count % 64 == 0) stall_style <= $urandom_range(0, 4);
         case (stall_style)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= cycle_count[0];
            2: rsp_stall <= ($urandom_range(0, 3) == 0);
            3: rsp_stall <= ($urandom_range(0, 1) == 0);
            default: rsp_stall <= (cycle_count % 16) < 11;
         endcase
      end
   end

   // Checker: every result transfer is matched against the oldest expectation.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         result_count++;
         if (expected_angles.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected result: slope %0d aspect %0d last %0d",
                        rsp_data.slope_angle, rsp_data.aspect_angle, rsp_data.frame_last);
         end else begin
            want = expected_angles.pop_front();
            if (rsp_data.slope_angle !== want.slope_angle ||
                rsp_data.aspect_angle !== want.aspect_angle ||
                rsp_data.frame_last !== want.frame_last) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch: expected slope %0d aspect %0d last %0d, got %0d %0d %0d",
                           want.slope_angle, want.aspect_angle, want.frame_last,
                           rsp_data.slope_angle, rsp_data.aspect_angle, rsp_data.frame_last);
            end
         end
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("terrain_slope_aspect_stencil regression: fail");
         $finish;
      end
   end

   // Register write over the configuration channel; the predictor copy follows on transfer.
   task automatic write_csr(input csr_index_type idx, input logic [15:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_GRID_COLUMNS:  grid_cols_reg = value[10:0];
         CSR_GRID_ROWS:     grid_rows_reg = value;
         CSR_INV_SPACING_X: inv_dx_reg = value;
         default:           inv_dy_reg = value;
      endcase
   endtask

   // Waits until every queued item went in and every expected result came out,
   // then lets the pipeline settle so dropped items are surely done too.
   task automatic wait_quiet();
      do @(posedge clock);
      while (pending_items.size() != 0 || req_valid || expected_angles.size() != 0);
      repeat (SETTLE) @(posedge clock);
   endtask

   // Appends one item to the sender's backlog.
   task automatic queue_item(input req_type item);
      pending_items.insert(pending_items.size(), item);
      queued_count++;
   endtask

   function automatic logic signed [23:0] pick_height(input logic signed [23:0] last_z,
                                                      input bit rough);
      int unsigned pick;
      int          delta;
      longint      z;
      pick = $urandom_range(0, 15);
      if (pick == 0) return 24'sh800000;
      if (pick == 1) return 24'sh7FFFFF;
      if (pick == 2) return 24'sh000000;
      if (rough || pick < 6) return 24'($urandom);
      delta = $urandom_range(0, 4096) - 2048;
      z = longint'(last_z) + delta;
      if (z > 8388607) z = 8388607;
      if (z < -8388608) z = -8388608;
      return 24'(z);
   endfunction

   // One frame: reprogram all registers while idle, push every sample, then drain
   // the last row. With noise set, dropped drains and pushes are mixed in.
   task automatic run_frame(input logic [15:0] cols_val, input logic [15:0] rows_val,
                            input logic [15:0] sx, input logic [15:0] sy,
                            input bit rough, input bit noise);
      req_type     item;
      int unsigned cols;
      int unsigned rows;
      int unsigned total;
      logic signed [23:0] z;
      wait_quiet();
      write_csr(CSR_GRID_COLUMNS, cols_val);
      write_csr(CSR_GRID_ROWS, rows_val);
      write_csr(CSR_INV_SPACING_X, sx);
      write_csr(CSR_INV_SPACING_Y, sy);
      cols = active_cols();
      rows = active_rows();
      total = cols * rows;
      z = 24'($urandom);
      for (int unsigned i = 0; i < total; i++) begin
         if (noise && $urandom_range(0, 15) == 0) begin
            item.cmd = 1'b1;
            item.elevation = 24'($urandom);
            queue_item(item);
         end
         z = pick_height(z, rough);
         item.cmd = 1'b0;
         item.elevation = z;
         queue_item(item);
      end
      for (int unsigned i = 0; i < cols; i++) begin
         if (noise && $urandom_range(0, 7) == 0) begin
            item.cmd = 1'b0;
            item.elevation = 24'($urandom);
            queue_item(item);
         end
         item.cmd = 1'b1;
         item.elevation = 24'($urandom);
         queue_item(item);
      end
      frame_count++;
   endtask

   initial begin
      int unsigned cols_pick;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_data       = '0;
      rsp_stall      = 1'b0;
      csr_valid      = 1'b0;
      csr_index      = CSR_GRID_COLUMNS;
      csr_data       = '0;
      cycle_count    = 0;
      mismatch_count = 0;
      result_count   = 0;
      accepted_count = 0;
      queued_count   = 0;
      frame_count    = 0;
      grid_cols_reg  = GRID_COLUMNS_RESET;
      grid_rows_reg  = GRID_ROWS_RESET;
      inv_dx_reg     = INV_SPACING_RESET;
      inv_dy_reg     = INV_SPACING_RESET;
      pixel_col      = 0;
      pixel_row      = 0;
      line_toggle    = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed frames: a single pixel (zero gradient), zero-register values acting as
      // one, a one-wide column, a one-high row, zero and full-scale spacings, extreme
      // heights on a tiny grid, and a zero east-west spacing that puts the gradient on an axis.
      run_frame(16'd1, 16'd1, 16'd4096, 16'd4096, 1'b1, 1'b0);
      run_frame(16'd0, 16'd0, 16'd0, 16'd0, 1'b1, 1'b0);
      run_frame(16'd1, 16'd4, 16'd65535, 16'd65535, 1'b1, 1'b1);
      run_frame(16'd5, 16'd1, 16'd65535, 16'd1, 1'b1, 1'b1);
      run_frame(16'd2, 16'd3, 16'd65535, 16'd65535, 1'b1, 1'b0);
      run_frame(16'd3, 16'd2, 16'd0, 16'd4096, 1'b0, 1'b0);

      // A wider row pair and a tall one-column strip.
      run_frame(16'd40, 16'd2, 16'($urandom), 16'($urandom), 1'b0, 1'b1);
      run_frame(16'd1, 16'd60, 16'($urandom), 16'($urandom), 1'b0, 1'b0);

      // Random frames, mostly small, with noise in about half of them.
      while (queued_count < 920) begin
         cols_pick = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 24)
                                                 : $urandom_range(1, 12);
         run_frame(16'(cols_pick), 16'($urandom_range(1, 9)),
                   ($urandom_range(0, 7) == 0) ? 16'hFFFF : 16'($urandom),
                   ($urandom_range(0, 7) == 0) ? 16'h0000 : 16'($urandom),
                   1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
         if (frame_count > 120) break;
      end

      wait_quiet();
      $display("covered %0d frames, %0d accepted items, %0d results checked",
               frame_count, accepted_count, result_count);
      if (mismatch_count == 0 && expected_angles.size() == 0) begin
         $display("terrain_slope_aspect_stencil regression: pass");
      end else begin
         $display("%0d mismatches, %0d results still owed", mismatch_count,
                  expected_angles.size());
         $display("terrain_slope_aspect_stencil regression: fail");
      end
      $finish;
   end

endmodule

`default_nettype wire
